>>> rtl/lsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap stopwatch package
// Mode codes, action codes and the command and status types that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package lsc_pkg;

	localparam logic [2:0] MODE_PAUSED = 3'd0;
	localparam logic [2:0] MODE_UP     = 3'd1;
	localparam logic [2:0] MODE_DOWN   = 3'd2;
	localparam logic [2:0] MODE_VIEW   = 3'd3;
	localparam logic [2:0] MODE_BRIGHT = 3'd4;
	localparam logic [2:0] MODE_INIT   = 3'd5;

	localparam logic [2:0] ACT_TICK        = 3'd0;
	localparam logic [2:0] ACT_UP          = 3'd1;
	localparam logic [2:0] ACT_UP_LONG     = 3'd2;
	localparam logic [2:0] ACT_DOWN        = 3'd3;
	localparam logic [2:0] ACT_DOWN_LONG   = 3'd4;
	localparam logic [2:0] ACT_SELECT      = 3'd5;
	localparam logic [2:0] ACT_SELECT_LONG = 3'd6;
	localparam logic [2:0] ACT_IDLE        = 3'd7;

	localparam logic [6:0] BRIGHT_RESET = 7'd80;
	localparam logic [6:0] BRIGHT_MAX   = 7'd100;
	localparam logic [6:0] BRIGHT_STEP  = 7'd20;
	localparam logic [31:0] MAX_TIME_RESET = 32'd6000000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // latch the event
		logic start_last; // start from the newest lap
		logic start_up0;  // count-up from zero
		logic start_dmax; // count-down from the maximum
		logic tick_up;    // begin the modulo for a count-up tick
		logic tick_down;  // count-down tick
		logic store;      // store current value as a lap
		logic view_new;   // view pointer to newest
		logic view_inc;
		logic view_dec;
		logic br_inc;
		logic br_dec;
	} lsc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       mod_done;
		logic [2:0] action;
	} lsc_stat_t;

endpackage

>>> rtl/lsc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap stopwatch datapath
// Time registers, lap ring, pointers, brightness and a bit-serial modulo
// unit used by count-up ticks.
// ----------------------------------------------------------------------------
module lsc_datapath #(
	parameter int LAP_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	input  logic [2:0]        in_action,
	input  logic [31:0]       in_now_ms,
	input  lsc_pkg::lsc_cmd_t cmd,
	output lsc_pkg::lsc_stat_t stat,
	output logic [31:0]       shown_time,
	output logic [31:0]       viewed_time,
	output logic [3:0]        stored_count,
	output logic [6:0]        brightness,
	output logic              none_found
);
	import lsc_pkg::*;

	localparam int PW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
	localparam int CW = $clog2(LAP_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(LAP_DEPTH - 1);

	logic [31:0] max_q, start_q, up_base_q, down_base_q, cur_q, now_q;
	logic [2:0]  act_q;
	logic [31:0] ring_q [LAP_DEPTH];
	logic [PW-1:0] wp_q, vp_q;
	logic [CW-1:0] cnt_q;
	logic [6:0]  br_q;

	// Serial modulo state: 33-bit dividend, remainder, bit counter.
	logic [32:0] div_q;
	logic [32:0] rem_q;
	logic [5:0]  bit_q;
	logic        busy_q;
	logic        mod_done_q;

	logic [PW-1:0] newest, oldest;
	logic [CW:0]   old_sum;
	logic [31:0]   elapsed, dval, last_lap;
	logic [33:0]   rem_sh;

	function automatic logic [PW-1:0] inc_p(input logic [PW-1:0] p);
		inc_p = (p == LAST) ? '0 : p + PW'(1);
	endfunction
	function automatic logic [PW-1:0] dec_p(input logic [PW-1:0] p);
		dec_p = (p == '0) ? LAST : p - PW'(1);
	endfunction

	// Ring index helpers; the oldest entry sits lap-count slots behind the
	// write pointer, taken modulo the ring depth.
	always_comb begin
		newest   = dec_p(wp_q);
		old_sum  = (CW+1)'(wp_q) + (CW+1)'(LAP_DEPTH) - {1'b0, cnt_q};
		oldest   = (old_sum >= (CW+1)'(LAP_DEPTH)) ?
			PW'(old_sum - (CW+1)'(LAP_DEPTH)) : PW'(old_sum);
		elapsed  = now_q - start_q;
		dval     = down_base_q - elapsed;
		last_lap = ring_q[newest];
		rem_sh   = {rem_q, div_q[32]};
	end

	// Control registers and arithmetic.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= MAX_TIME_RESET;
			start_q     <= '0;
			up_base_q   <= '0;
			down_base_q <= MAX_TIME_RESET;
			cur_q       <= '0;
			wp_q        <= '0;
			vp_q        <= '0;
			cnt_q       <= '0;
			br_q        <= BRIGHT_RESET;
			busy_q      <= 1'b0;
			bit_q       <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			none_found  <= 1'b0;
			mod_done_q  <= 1'b0;
		end else begin
			mod_done_q <= 1'b0;
			if (cfg_we)
				max_q <= cfg_wdata;
			if (cmd.load)
				none_found <= 1'b0;
			if (cmd.start_last) begin
				start_q <= now_q;
				if (cnt_q == '0) begin
					up_base_q   <= '0;
					down_base_q <= max_q;
					none_found  <= 1'b1;
				end else begin
					up_base_q   <= last_lap;
					down_base_q <= last_lap;
				end
			end
			if (cmd.start_up0) begin
				start_q   <= now_q;
				up_base_q <= '0;
				cur_q     <= '0;
			end
			if (cmd.start_dmax) begin
				start_q     <= now_q;
				down_base_q <= max_q;
				cur_q       <= '0;
			end
			if (cmd.tick_down) begin
				if (max_q != '0 && dval > max_q) begin
					start_q     <= now_q;
					down_base_q <= max_q;
					cur_q       <= max_q;
				end else
					cur_q <= dval;
			end
			// Restoring division, one dividend bit a cycle; the sum wraps at
			// 32 bits, and a zero maximum means 2^32.
			if (cmd.tick_up) begin
				busy_q <= 1'b1;
				bit_q  <= 6'd33;
				div_q  <= {1'b0, up_base_q + elapsed};
				rem_q  <= '0;
			end else if (busy_q) begin
				div_q <= {div_q[31:0], 1'b0};
				if (rem_sh >= {1'b0, (max_q == '0), max_q})
					rem_q <= 33'(rem_sh - {1'b0, (max_q == '0), max_q});
				else
					rem_q <= rem_sh[32:0];
				bit_q <= bit_q - 6'd1;
				if (bit_q == 6'd1) begin
					busy_q     <= 1'b0;
					mod_done_q <= 1'b1;
				end
			end
			if (mod_done_q)
				cur_q <= rem_q[31:0];
			if (cmd.store) begin
				wp_q <= inc_p(wp_q);
				if (cnt_q != CW'(LAP_DEPTH))
					cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.view_new)
				vp_q <= newest;
			if (cmd.view_inc && cnt_q != '0 && vp_q != newest)
				vp_q <= inc_p(vp_q);
			if (cmd.view_dec && cnt_q != '0 && vp_q != oldest)
				vp_q <= dec_p(vp_q);
			if (cmd.br_inc)
				br_q <= (br_q >= BRIGHT_RESET) ? BRIGHT_MAX : br_q + BRIGHT_STEP;
			if (cmd.br_dec)
				br_q <= (br_q <= BRIGHT_STEP) ? '0 : br_q - BRIGHT_STEP;
		end
	end

	// Event latch and lap ring storage.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			now_q <= in_now_ms;
		end
		if (cmd.store)
			ring_q[wp_q] <= cur_q;
	end

	assign stat         = '{mod_done: mod_done_q, action: act_q};
	assign shown_time   = cur_q;
	assign viewed_time  = (cnt_q == '0) ? '0 : ring_q[vp_q];
	assign stored_count = 4'(cnt_q);
	assign brightness   = br_q;
endmodule

>>> rtl/lsc_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap stopwatch controller
// Handshake sequencer and mode transition table.
// ----------------------------------------------------------------------------
module lsc_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  lsc_pkg::lsc_stat_t stat,
	output lsc_pkg::lsc_cmd_t  cmd,
	output logic [2:0]         mode,
	output logic               saved_notice
);
	import lsc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q, state_d;
	logic [2:0] mode_q, mode_d;
	logic       saved_q, saved_d;
	logic [2:0] a;

	assign a         = stat.action;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign mode      = mode_q;
	assign saved_notice = saved_q;

	// Sequencer and the transition table.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		mode_d  = mode_q;
		saved_d = saved_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					saved_d  = 1'b0;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_OUT;
				case (mode_q)
					MODE_INIT: begin
						if (a != ACT_TICK && a != ACT_IDLE)
							mode_d = MODE_PAUSED;
					end
					MODE_PAUSED: begin
						case (a)
							ACT_UP: begin
								cmd.start_last = 1'b1;
								mode_d = MODE_UP;
							end
							ACT_UP_LONG: begin
								cmd.start_up0 = 1'b1;
								mode_d = MODE_UP;
							end
							ACT_DOWN: begin
								cmd.start_last = 1'b1;
								mode_d = MODE_DOWN;
							end
							ACT_DOWN_LONG: begin
								cmd.start_dmax = 1'b1;
								mode_d = MODE_DOWN;
							end
							ACT_SELECT_LONG: begin
								cmd.view_new = 1'b1;
								mode_d = MODE_VIEW;
							end
							ACT_SELECT: mode_d = MODE_BRIGHT;
							default: ;
						endcase
					end
					MODE_UP: begin
						if (a == ACT_TICK) begin
							cmd.tick_up = 1'b1;
							state_d = ST_WAIT;
						end else if (a == ACT_UP) begin
							cmd.store = 1'b1;
							saved_d = 1'b1;
						end else if (a == ACT_SELECT)
							mode_d = MODE_PAUSED;
					end
					MODE_DOWN: begin
						if (a == ACT_TICK)
							cmd.tick_down = 1'b1;
						else if (a == ACT_DOWN) begin
							cmd.store = 1'b1;
							saved_d = 1'b1;
						end else if (a == ACT_SELECT)
							mode_d = MODE_PAUSED;
					end
					MODE_VIEW: begin
						if (a == ACT_UP)
							cmd.view_inc = 1'b1;
						else if (a == ACT_DOWN)
							cmd.view_dec = 1'b1;
						else if (a == ACT_SELECT)
							mode_d = MODE_PAUSED;
					end
					MODE_BRIGHT: begin
						if (a == ACT_UP)
							cmd.br_inc = 1'b1;
						else if (a == ACT_DOWN)
							cmd.br_dec = 1'b1;
						else if (a == ACT_SELECT || a == ACT_IDLE)
							mode_d = MODE_PAUSED;
					end
					default: ;
				endcase
			end
			ST_WAIT: begin
				if (stat.mod_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_INIT;
			saved_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			saved_q <= saved_d;
		end
	end
endmodule

>>> rtl/lap_stopwatch_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap stopwatch controller, top level
// Six-mode stopwatch with count-up, count-down, a lap ring and brightness.
//
//   Channel   Handshake               Beat contents
//   input     in_valid / in_ready     action, now_ms
//   output    out_valid / out_ready   mode, shown_time, viewed_time,
//                                     stored_count, brightness, notices
//   config    cfg_we                  cfg_wdata = max_time_ms
//
// An event's result leaves from the OUT state, after the EXEC state that
// follows its input beat; the next input beat is taken back in IDLE.
// A count-up tick passes through a WAIT state between EXEC and OUT, while
// a bit-serial modulo by the maximum runs 33 steps and then signals done.
// One event is in flight at a time; a stalled result holds the block.
// Reset is asynchronous and does not clear the lap ring; while the lap
// count is zero the view reads zero.
// ----------------------------------------------------------------------------
module lap_stopwatch_controller #(
	parameter int LAP_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  mode,
	output logic [31:0] shown_time,
	output logic [31:0] viewed_time,
	output logic [3:0]  stored_count,
	output logic [6:0]  brightness,
	output logic        saved_notice,
	output logic        none_saved_notice
);
	import lsc_pkg::*;

	lsc_cmd_t  cmd;
	lsc_stat_t stat;

	// Sequencer and transition table.
	lsc_controller u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd, .mode, .saved_notice
	);

	// Registers, lap ring and modulo unit.
	lsc_datapath #(.LAP_DEPTH(LAP_DEPTH)) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.in_action(action), .in_now_ms(now_ms),
		.cmd, .stat, .shown_time, .viewed_time, .stored_count, .brightness,
		.none_found(none_saved_notice)
	);
endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap stopwatch controller testbench
// Drives button and tick beats with random gaps and random result stalls.
// A behavioral copy of the stopwatch predicts every result beat, and each
// result is compared field by field in order. The maximum time is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import lsc_pkg::*;

	localparam int RING_SIZE = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 50;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] shown;
		logic [31:0] viewed;
		logic [3:0]  count;
		logic [6:0]  bright;
		logic        saved;
		logic        none_saved;
	} display_t;

	typedef struct {
		logic [2:0]  act;
		logic [31:0] stamp;
		bit          typed;
		display_t    want;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  action = ACT_TICK;
	logic [31:0] now_ms = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  mode;
	logic [31:0] shown_time;
	logic [31:0] viewed_time;
	logic [3:0]  stored_count;
	logic [6:0]  brightness;
	logic        saved_notice;
	logic        none_saved_notice;

	// Stopwatch state as the predictor sees it.
	logic [31:0] p_max;
	logic [2:0]  p_mode;
	logic [31:0] p_stamp;
	logic [31:0] p_up_base;
	logic [31:0] p_down_base;
	logic [31:0] p_value;
	logic [31:0] p_laps [RING_SIZE];
	logic [2:0]  p_wr;
	logic [3:0]  p_count;
	logic [2:0]  p_view;
	logic [6:0]  p_bright;

	display_t  pending_displays [$];
	step_row_t typed_rows [$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        burst = 1'b0;

	always #5 clk = ~clk;

	lap_stopwatch_controller i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .now_ms(now_ms),
		.out_valid(out_valid), .out_ready(out_ready), .mode(mode),
		.shown_time(shown_time), .viewed_time(viewed_time),
		.stored_count(stored_count), .brightness(brightness),
		.saved_notice(saved_notice), .none_saved_notice(none_saved_notice)
	);

	function automatic logic [2:0] newest_slot();
		return p_wr - 3'd1;
	endfunction

	function automatic logic [2:0] oldest_slot();
		return 3'(p_wr - p_count);
	endfunction

	// Start from the newest lap, or from the defaults when none is stored.
	function automatic bit start_from_lap(logic [31:0] stamp);
		p_stamp = stamp;
		if (p_count == 0) begin
			p_up_base = '0;
			p_down_base = p_max;
			return 1'b1;
		end
		p_down_base = p_laps[newest_slot()];
		p_up_base = p_down_base;
		return 1'b0;
	endfunction

	function automatic void store_lap();
		p_laps[p_wr] = p_value;
		p_wr = p_wr + 3'd1;
		if (p_count < RING_SIZE)
			p_count = p_count + 4'd1;
	endfunction

	// Apply one event to the stopwatch state and return the display it gives.
	function automatic display_t stopwatch_step(logic [2:0] act, logic [31:0] stamp);
		display_t d;
		logic [31:0] v;
		d.saved = 1'b0;
		d.none_saved = 1'b0;
		case (p_mode)
			MODE_INIT: begin
				if (act != ACT_TICK && act != ACT_IDLE)
					p_mode = MODE_PAUSED;
			end
			MODE_PAUSED: begin
				case (act)
					ACT_UP: begin
						d.none_saved = start_from_lap(stamp);
						p_mode = MODE_UP;
					end
					ACT_UP_LONG: begin
						p_stamp = stamp;
						p_up_base = '0;
						p_value = '0;
						p_mode = MODE_UP;
					end
					ACT_DOWN: begin
						d.none_saved = start_from_lap(stamp);
						p_mode = MODE_DOWN;
					end
					ACT_DOWN_LONG: begin
						p_stamp = stamp;
						p_down_base = p_max;
						p_value = '0;
						p_mode = MODE_DOWN;
					end
					ACT_SELECT_LONG: begin
						p_view = newest_slot();
						p_mode = MODE_VIEW;
					end
					ACT_SELECT: p_mode = MODE_BRIGHT;
					default: ;
				endcase
			end
			MODE_UP: begin
				if (act == ACT_TICK) begin
					v = p_up_base + (stamp - p_stamp);
					p_value = (p_max != 0) ? v % p_max : v;
				end else if (act == ACT_UP) begin
					store_lap();
					d.saved = 1'b1;
				end else if (act == ACT_SELECT)
					p_mode = MODE_PAUSED;
			end
			MODE_DOWN: begin
				if (act == ACT_TICK) begin
					v = p_down_base - (stamp - p_stamp);
					if (p_max != 0 && v > p_max) begin
						p_stamp = stamp;
						p_down_base = p_max;
						v = p_max;
					end
					p_value = v;
				end else if (act == ACT_DOWN) begin
					store_lap();
					d.saved = 1'b1;
				end else if (act == ACT_SELECT)
					p_mode = MODE_PAUSED;
			end
			MODE_VIEW: begin
				if (act == ACT_UP) begin
					if (p_count != 0 && p_view != newest_slot())
						p_view = p_view + 3'd1;
				end else if (act == ACT_DOWN) begin
					if (p_count != 0 && p_view != oldest_slot())
						p_view = p_view - 3'd1;
				end else if (act == ACT_SELECT)
					p_mode = MODE_PAUSED;
			end
			MODE_BRIGHT: begin
				if (act == ACT_UP)
					p_bright = (p_bright >= 80) ? BRIGHT_MAX : p_bright + BRIGHT_STEP;
				else if (act == ACT_DOWN)
					p_bright = (p_bright <= 20) ? 7'd0 : p_bright - BRIGHT_STEP;
				else if (act == ACT_SELECT || act == ACT_IDLE)
					p_mode = MODE_PAUSED;
			end
			default: ;
		endcase
		d.mode = p_mode;
		d.shown = p_value;
		d.viewed = (p_count == 0) ? 32'd0 : p_laps[p_view];
		d.count = p_count;
		d.bright = p_bright;
		return d;
	endfunction

	// Input beats advance the predictor, result beats are checked in order.
	always @(posedge clk) begin
		display_t want;
		display_t got;
		step_row_t row;
		if (in_valid && in_ready) begin
			want = stopwatch_step(action, now_ms);
			if (typed_rows.size() != 0) begin
				row = typed_rows.pop_front();
				if (row.typed)
					want = row.want;
			end
			pending_displays.push_back(want);
		end
		if (out_valid && out_ready) begin
			got = '{mode, shown_time, viewed_time, stored_count, brightness,
				saved_notice, none_saved_notice};
			if (pending_displays.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %p", got);
			end else begin
				want = pending_displays.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("** lap_stopwatch_controller: FAILED **");
			$finish;
		end
	end

	// Result side: random stall before each result beat.
	initial begin
		int stall;
		forever begin
			@(negedge clk);
			stall = burst ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
		end
	end

	// Send one event beat after a random gap; returns at the falling edge.
	task automatic send_event(logic [2:0] act, logic [31:0] stamp);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		now_ms = stamp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Write the maximum time once every result is back and the block is quiet.
	task automatic write_max_time(logic [31:0] value);
		while (pending_displays.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		p_max = value;
	endtask

	function automatic step_row_t row(logic [2:0] act, logic [31:0] stamp, bit typed = 0,
		logic [2:0] m = 0, logic [31:0] shown = 0, logic [31:0] viewed = 0,
		logic [3:0] cnt = 0, bit saved = 0, bit none_saved = 0);
		step_row_t r;
		r.act = act;
		r.stamp = stamp;
		r.typed = typed;
		r.want = '{m, shown, viewed, cnt, BRIGHT_RESET, saved, none_saved};
		return r;
	endfunction

	function automatic logic [2:0] pick_action();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return ACT_TICK;
		if (r < 55) return ACT_UP;
		if (r < 65) return ACT_DOWN;
		if (r < 79) return ACT_SELECT;
		if (r < 85) return ACT_SELECT_LONG;
		if (r < 90) return ACT_UP_LONG;
		if (r < 95) return ACT_DOWN_LONG;
		return ACT_IDLE;
	endfunction

	// Random phase: mostly a steadily advancing clock, now and then a jump.
	task automatic random_phase(int count);
		logic [31:0] stamp;
		stamp = $urandom;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 19) == 0)
				stamp = $urandom;
			else
				stamp = stamp + $urandom_range(0, 3000);
			send_event(pick_action(), stamp);
		end
		burst = 1'b0;
	endtask

	initial begin
		step_row_t directed [$];
		p_max = MAX_TIME_RESET;
		p_mode = MODE_INIT;
		p_stamp = '0;
		p_up_base = '0;
		p_down_base = MAX_TIME_RESET;
		p_value = '0;
		foreach (p_laps[i]) p_laps[i] = '0;
		p_wr = '0;
		p_count = '0;
		p_view = '0;
		p_bright = BRIGHT_RESET;

		// Directed walk through every mode and the special cases.
		directed = '{
			row(ACT_TICK, 5, 1, MODE_INIT),
			row(ACT_IDLE, 6, 1, MODE_INIT),
			row(ACT_UP, 7, 1, MODE_PAUSED),
			row(ACT_UP, 1000, 1, MODE_UP, 0, 0, 0, 0, 1),
			row(ACT_TICK, 1500, 1, MODE_UP, 500),
			row(ACT_UP, 1600, 1, MODE_UP, 500, 500, 1, 1, 0),
			row(ACT_TICK, 32'hFFFF_FFFF),
			row(ACT_SELECT, 0),
			row(ACT_DOWN, 100),
			row(ACT_TICK, 400, 1, MODE_DOWN, 200, 500, 1),
			row(ACT_TICK, 700, 1, MODE_DOWN, MAX_TIME_RESET, 500, 1),
			row(ACT_DOWN, 710),
			row(ACT_SELECT, 720),
			row(ACT_DOWN_LONG, 0),
			row(ACT_TICK, 0),
			row(ACT_SELECT, 1),
			row(ACT_UP_LONG, 32'hFFFF_FF00),
			row(ACT_TICK, 32'h0000_00FF),
			row(ACT_IDLE, 2),
			row(ACT_SELECT, 3),
			row(ACT_SELECT_LONG, 4),
			row(ACT_UP, 5), row(ACT_DOWN, 6), row(ACT_DOWN, 7), row(ACT_DOWN, 8),
			row(ACT_UP, 9), row(ACT_SELECT, 10), row(ACT_SELECT, 11),
			row(ACT_UP, 12), row(ACT_UP, 13),
			row(ACT_DOWN, 14), row(ACT_DOWN, 15), row(ACT_DOWN, 16), row(ACT_DOWN, 17),
			row(ACT_DOWN, 18), row(ACT_DOWN, 19), row(ACT_IDLE, 20)
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			typed_rows.push_back(directed[i]);
			send_event(directed[i].act, directed[i].stamp);
		end

		random_phase(250);
		write_max_time(32'd1);
		random_phase(200);
		write_max_time(32'hFFFF_FFFF);
		random_phase(200);
		write_max_time(32'd1000);
		random_phase(250);
		write_max_time(32'd7000);
		random_phase(250);

		while (pending_displays.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("** lap_stopwatch_controller: PASSED **");
		else
			$display("** lap_stopwatch_controller: FAILED **");
		$finish;
	end

endmodule
